/* hdl/pla_pkg.sv */
// pla_pkg: shared types and constants of the printer line assembler
// no dependencies; imported by printer_line_assembler_unit
package pla_pkg;

    localparam logic [7:0] CH_BS      = 8'd8;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_VT      = 8'd11;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam int unsigned BEAT_BYTES = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EMIT_RD,
        ST_EMIT_PACK,
        ST_NL,
        ST_FLUSH
    } pla_state_t;

    // place one byte into lane lane_idx of a beat word
    function automatic logic [31:0] lane_put(input logic [31:0] word,
                                             input logic [1:0]  lane_idx,
                                             input logic [7:0]  b);
        logic [31:0] res;
        res = word;
        unique case (lane_idx)
            2'd0: res[7:0]   = b;
            2'd1: res[15:8]  = b;
            2'd2: res[23:16] = b;
            2'd3: res[31:24] = b;
            default: res = word;
        endcase
        return res;
    endfunction

endpackage

/* hdl/pla_line_store.sv */
// pla_line_store: single-port-write, single-read line memory with registered read data
// no dependencies; instantiated by printer_line_assembler_unit
module pla_line_store #(
    parameter int DEPTH = 120,
    parameter int AW    = 7
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/printer_line_assembler_unit.sv */
// printer_line_assembler_unit: top level, line composition, trim scan and beat packing
// depends on pla_pkg and pla_line_store
//
// Printer bytes enter one per beat. A printable byte, a backspace or an ignored control
// byte is taken while the block is idle, and the input stays ready. A carriage return,
// line feed or vertical tab closes the line: the block scans the filled part of the line
// store cell by cell, then reads the trimmed line back byte by byte and packs it into
// output beats, holding a beat while the output waits on out_ready. These steps follow
// from the single read port of the line store and its registered read data, which one
// sequencer walks through cell by cell. The input is not ready while a line is being
// scanned or sent. The store is tracked by a fill count, so no clearing pass runs after
// reset or between lines. Output beats carry up to four bytes, first byte in bits 7:0,
// and the beat holding the trailing newline has last_of_line set. wp_mode is written
// through the cfg channel.
module printer_line_assembler_unit #(
    parameter int LINE_WIDTH = 120
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_bytes,
    output logic [2:0]  out_count,
    output logic        last_of_line,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        wp_mode
);

    import pla_pkg::*;

    localparam int AW = $clog2(LINE_WIDTH);
    localparam int CW = $clog2(LINE_WIDTH + 1);

    pla_state_t    state_reg, state_next;
    logic [CW-1:0] cursor_reg, cursor_next;
    logic [CW-1:0] hw_reg, hw_next;
    logic          parity_reg, parity_next;
    logic          wp_mode_reg;
    logic          out_valid_reg, out_valid_next;

    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] first_reg, first_next;
    logic [AW-1:0] last_reg, last_next;
    logic          found_reg, found_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [31:0]   word_reg, word_next;
    logic [2:0]    nbytes_reg, nbytes_next;
    logic          flush_last_reg, flush_last_next;
    logic [31:0]   out_bytes_reg, out_bytes_next;
    logic [2:0]    out_count_reg, out_count_next;
    logic          out_last_reg, out_last_next;

    logic          wr_en;
    logic [7:0]    rd_data;
    logic          is_char;
    logic [AW-1:0] scan_first, scan_last;
    logic          scan_found;
    logic          out_free;

    pla_line_store #(
        .DEPTH (LINE_WIDTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cursor_reg[AW-1:0]),
        .wr_data (char_byte),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign in_ready     = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign out_bytes    = out_bytes_reg;
    assign out_count    = out_count_reg;
    assign last_of_line = out_last_reg;
    assign out_free     = !out_valid_reg || out_ready;

    // running trim bounds including the cell now on the read port
    assign is_char    = (rd_data != CH_SPACE);
    assign scan_first = (is_char && !found_reg) ? idx_reg : first_reg;
    assign scan_last  = is_char ? idx_reg : last_reg;
    assign scan_found = found_reg || is_char;

    always_comb
    begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        hw_next         = hw_reg;
        parity_next     = parity_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        idx_next        = idx_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        found_next      = found_reg;
        rem_next        = rem_reg;
        word_next       = word_reg;
        nbytes_next     = nbytes_reg;
        flush_last_next = flush_last_reg;
        out_bytes_next  = out_bytes_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (char_byte == CH_CR || char_byte == CH_LF ||
                                 char_byte == CH_VT)
                    begin
                        if (hw_reg == '0)
                        begin
                            cursor_next = '0;
                        end
                        else
                        begin
                            idx_next   = '0;
                            found_next = 1'b0;
                            state_next = ST_SCAN_RD;
                        end
                    end
                    else if (char_byte == CH_BS)
                    begin
                        if (cursor_reg != '0)
                        begin
                            cursor_next = cursor_reg - CW'(1);
                        end
                    end
                    else if (char_byte >= CH_SPACE)
                    begin
                        if (cursor_reg < CW'(LINE_WIDTH))
                        begin
                            wr_en       = 1'b1;
                            cursor_next = cursor_reg + CW'(1);
                            // written cells are always 0 .. hw-1
                            if (cursor_reg == hw_reg)
                            begin
                                hw_next = hw_reg + CW'(1);
                            end
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CHK;
            end

            ST_SCAN_CHK:
            begin
                first_next = scan_first;
                last_next  = scan_last;
                found_next = scan_found;
                if (CW'(idx_reg) + CW'(1) == hw_reg)
                begin
                    if (scan_found)
                    begin
                        idx_next    = parity_reg ? scan_last : scan_first;
                        rem_next    = CW'(scan_last) - CW'(scan_first) + CW'(1);
                        word_next   = '0;
                        nbytes_next = '0;
                        state_next  = ST_EMIT_RD;
                    end
                    else
                    begin
                        // blank line: nothing sent, parity kept
                        cursor_next = '0;
                        hw_next     = '0;
                        state_next  = ST_IDLE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_SCAN_RD;
                end
            end

            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_PACK;
            end

            ST_EMIT_PACK:
            begin
                word_next   = lane_put(word_reg, nbytes_reg[1:0], rd_data);
                nbytes_next = nbytes_reg + 3'd1;
                rem_next    = rem_reg - CW'(1);
                idx_next    = parity_reg ? (idx_reg - AW'(1)) : (idx_reg + AW'(1));
                priority if (nbytes_reg == 3'(BEAT_BYTES - 1))
                begin
                    flush_last_next = 1'b0;
                    state_next      = ST_FLUSH;
                end
                else if (rem_reg == CW'(1))
                begin
                    state_next = ST_NL;
                end
                else
                begin
                    state_next = ST_EMIT_RD;
                end
            end

            ST_NL:
            begin
                word_next       = lane_put(word_reg, nbytes_reg[1:0], CH_NEWLINE);
                nbytes_next     = nbytes_reg + 3'd1;
                flush_last_next = 1'b1;
                state_next      = ST_FLUSH;
            end

            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_bytes_next = word_reg;
                    out_count_next = nbytes_reg;
                    out_last_next  = flush_last_reg;
                    word_next      = '0;
                    nbytes_next    = '0;
                    priority if (flush_last_reg)
                    begin
                        parity_next = parity_reg ^ wp_mode_reg;
                        cursor_next = '0;
                        hw_next     = '0;
                        state_next  = ST_IDLE;
                    end
                    else if (rem_reg == '0)
                    begin
                        state_next = ST_NL;
                    end
                    else
                    begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cursor_reg    <= '0;
            hw_reg        <= '0;
            parity_reg    <= 1'b0;
            wp_mode_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            hw_reg        <= hw_next;
            parity_reg    <= parity_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                wp_mode_reg <= wp_mode;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        first_reg      <= first_next;
        last_reg       <= last_next;
        found_reg      <= found_next;
        rem_reg        <= rem_next;
        word_reg       <= word_next;
        nbytes_reg     <= nbytes_next;
        flush_last_reg <= flush_last_next;
        out_bytes_reg  <= out_bytes_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    a_cursor_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= hw_reg)
        else $error("cursor beyond fill count");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hw_reg <= CW'(LINE_WIDTH))
        else $error("fill count beyond line width");

    a_scan_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_CHK) |-> (CW'(idx_reg) < hw_reg))
        else $error("scan read outside filled cells");

    a_nl_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NL) |-> (nbytes_reg < 3'(BEAT_BYTES)))
        else $error("newline with full beat word");

    a_beat_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_count_reg != 3'd0 && out_count_reg <= 3'(BEAT_BYTES)))
        else $error("output beat byte count out of range");

endmodule

/* test/printer_line_assembler_unit_tb.sv */
// printer_line_assembler_unit_tb: self-checking bench for the printer line assembler
// depends on pla_pkg and printer_line_assembler_unit; a shadow of the line store predicts
// every output beat, a queue-fed driver and a clocked monitor handle both channels
`timescale 1ns / 100ps

module printer_line_assembler_unit_tb;

    import pla_pkg::*;

    localparam int LINE_W = 120;

    typedef struct {
        logic [31:0] bytes;
        logic [2:0]  count;
        logic        last;
    } line_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  char_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] out_bytes;
    logic [2:0]  out_count;
    logic        last_of_line;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        wp_mode = 1'b0;

    // shadow of the block state
    logic [7:0]  cells [LINE_W];
    int          col;
    logic        odd_line;
    logic        wp_shadow;

    line_beat_t  beats_due [$];
    logic [7:0]  feed_q [$];
    logic        in_beat_done = 1'b0;
    logic        calm = 1'b0;
    int          fail_count = 0;

    printer_line_assembler_unit #(
        .LINE_WIDTH (LINE_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_byte    (char_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_bytes    (out_bytes),
        .out_count    (out_count),
        .last_of_line (last_of_line),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .wp_mode      (wp_mode)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // trim, optionally reverse, pack four bytes per beat, then clear the line
    function automatic void flush_line();
        logic [7:0] seq [$];
        line_beat_t bt;
        int lo;
        int hi;
        int i;
        int k;
        lo = -1;
        hi = -1;
        for (i = 0; i < LINE_W; i++)
        begin
            if (cells[i] != CH_SPACE)
            begin
                if (lo < 0)
                    lo = i;
                hi = i;
            end
        end
        if (lo >= 0)
        begin
            for (i = 0; i <= hi - lo; i++)
                seq.push_back(odd_line ? cells[hi - i] : cells[lo + i]);
            seq.push_back(CH_NEWLINE);
            for (i = 0; i < seq.size(); i += BEAT_BYTES)
            begin
                bt.bytes = '0;
                bt.count = '0;
                for (k = 0; k < BEAT_BYTES && i + k < seq.size(); k++)
                begin
                    bt.bytes[8*k +: 8] = seq[i + k];
                    bt.count = bt.count + 3'd1;
                end
                bt.last = (i + bt.count == seq.size());
                beats_due.push_back(bt);
            end
            if (wp_shadow)
                odd_line = ~odd_line;
        end
        for (i = 0; i < LINE_W; i++)
            cells[i] = CH_SPACE;
        col = 0;
    endfunction

    function automatic void compose_byte(input logic [7:0] b);
        if (b == CH_CR || b == CH_LF || b == CH_VT)
            flush_line();
        else if (b == CH_BS)
        begin
            if (col > 0)
                col--;
        end
        else if (b >= CH_SPACE)
        begin
            // right margin drops the byte
            if (col < LINE_W)
            begin
                cells[col] = b;
                col++;
            end
        end
    endfunction

    function automatic logic [7:0] ignored_ctrl();
        logic [7:0] b;
        b = 8'($urandom_range(31));
        while (b == CH_BS || b == CH_LF || b == CH_VT || b == CH_CR)
            b = 8'($urandom_range(31));
        return b;
    endfunction

    function automatic logic [7:0] line_end();
        int r;
        r = $urandom_range(2);
        return (r == 0) ? CH_CR : (r == 1) ? CH_LF : CH_VT;
    endfunction

    // one random line; returns the number of bytes queued
    function automatic int push_line();
        int span;
        int r;
        int k;
        int n;
        logic [7:0] b;
        n = 0;
        r = $urandom_range(99);
        if (r < 85)
            span = $urandom_range(16);
        else if (r < 95)
            span = $urandom_range(60, 17);
        else
            span = $urandom_range(130, 118);
        if ($urandom_range(99) < 10)
        begin
            // noise: raw bytes, terminators and all
            for (k = 0; k < span; k++)
                feed_q.push_back(8'($urandom_range(255)));
            return span;
        end
        if ($urandom_range(99) < 25)
        begin
            for (k = $urandom_range(4, 1); k > 0; k--)
            begin
                feed_q.push_back(CH_SPACE);
                n++;
            end
        end
        for (k = 0; k < span; k++)
        begin
            r = $urandom_range(99);
            if (r < 20)
                b = CH_SPACE;
            else if (r < 25)
                b = CH_BS;
            else if (r < 29)
                b = ignored_ctrl();
            else
                b = 8'($urandom_range(255, 33));
            feed_q.push_back(b);
            n++;
        end
        // a few lines run on into the next one
        if ($urandom_range(99) < 92)
        begin
            feed_q.push_back(line_end());
            n++;
        end
        return n;
    endfunction

    task automatic fill_random(input int target);
        int n;
        n = 0;
        while (n < target)
            n += push_line();
    endtask

    task automatic drain();
        while (feed_q.size() > 0 || in_valid || beats_due.size() > 0)
            @(posedge clk);
    endtask

    // the block may still scan a blank line after the last beat
    task automatic settle();
        drain();
        repeat (600) @(posedge clk);
    endtask

    task automatic write_wp(input logic val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        wp_mode   <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // input driver: hold a beat until taken, random gaps between beats
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_beat_done))
        begin
            if (feed_q.size() > 0 && (calm || $urandom_range(99) >= 38))
            begin
                char_byte <= feed_q.pop_front();
                in_valid  <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 38);
    end

    // monitor: check output beats, then feed accepted input into the shadow
    always @(posedge clk)
    begin
        line_beat_t want;
        in_beat_done <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (beats_due.size() == 0)
                begin
                    $error("unexpected output beat: out_bytes %h out_count %0d",
                           out_bytes, out_count);
                    fail_count++;
                end
                else
                begin
                    want = beats_due.pop_front();
                    if (out_bytes !== want.bytes)
                    begin
                        $error("out_bytes: expected %h, got %h", want.bytes, out_bytes);
                        fail_count++;
                    end
                    if (out_count !== want.count)
                    begin
                        $error("out_count: expected %0d, got %0d", want.count, out_count);
                        fail_count++;
                    end
                    if (last_of_line !== want.last)
                    begin
                        $error("last_of_line: expected %b, got %b", want.last, last_of_line);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                compose_byte(char_byte);
            if (cfg_valid && cfg_ready)
                wp_shadow = wp_mode;
        end
    end

    initial
    begin
        for (int i = 0; i < LINE_W; i++)
            cells[i] = CH_SPACE;
        col = 0;
        odd_line = 1'b0;
        wp_shadow = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_wp(1'b0);

        // directed: backspace at column zero, ignored controls, byte extremes
        feed_q.push_back(CH_BS);
        feed_q.push_back(8'h00);
        feed_q.push_back(8'h1F);
        feed_q.push_back(8'hFF);
        feed_q.push_back(8'h7F);
        feed_q.push_back(CH_SPACE);
        feed_q.push_back(8'h41);
        feed_q.push_back(CH_BS);
        feed_q.push_back(8'h42);
        feed_q.push_back(CH_CR);
        // blank line
        feed_q.push_back(CH_LF);
        // four bytes, newline alone in its own beat
        feed_q.push_back(8'h61);
        feed_q.push_back(8'h62);
        feed_q.push_back(8'h63);
        feed_q.push_back(8'h64);
        feed_q.push_back(CH_VT);
        // leading and trailing spaces trimmed
        feed_q.push_back(CH_SPACE);
        feed_q.push_back(CH_SPACE);
        feed_q.push_back(8'h80);
        feed_q.push_back(CH_SPACE);
        feed_q.push_back(CH_CR);
        settle();

        write_wp(1'b1);
        fill_random(80);
        settle();

        // no gaps on either side for this phase
        calm <= 1'b1;
        write_wp(1'b0);
        fill_random(80);
        settle();
        calm <= 1'b0;

        write_wp(1'b1);
        fill_random(35);
        drain();
        fill_random(35);
        settle();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hdl/pla_pkg.sv
hdl/pla_line_store.sv
hdl/printer_line_assembler_unit.sv
test/printer_line_assembler_unit_tb.sv
